// ----- hdl/scanline_edge_table_fill_top_defines.svh -----
// ----------------------------------------------------------------------------
// scanline edge table fill - assertion macros
// shared helpers for the concurrent checks at the top level
// ----------------------------------------------------------------------------
`ifndef SCANLINE_EDGE_TABLE_FILL_TOP_DEFINES_SVH
`define SCANLINE_EDGE_TABLE_FILL_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SETF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SETF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/setf_pkg.sv -----
// ----------------------------------------------------------------------------
// setf_pkg
// shared types and constants of the scanline edge table fill block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package setf_pkg;

    localparam int ROWS      = 1024;
    localparam int COLS      = 1024;
    localparam int FRAC_BITS = 16;

    // item field widths
    localparam int COORD_W = 10;
    localparam int LEFT_W  = 11;
    localparam int RIGHT_W = 10;

    // fixed point: x is unsigned Q10.F, slope is signed Q11.F
    localparam int X_W     = COORD_W + FRAC_BITS;
    localparam int SLOPE_W = X_W + 1;
    localparam int SUM_W   = SLOPE_W + 1;

    localparam int ROW_AW  = $clog2(ROWS);
    localparam int DIV_CW  = $clog2(X_W);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [COORD_W-1:0]   lo_x;
        logic [COORD_W-1:0]   lo_y;
        logic [COORD_W-1:0]   hi_y;
        logic [COORD_W-1:0]   dx_mag;
        logic                 dx_neg;
        logic [COORD_W-1:0]   dy;
        logic                 flat;
        logic [COORD_W-1:0]   query_row;
        logic                 qrow_ok;
    } t_cmd;

    typedef struct packed {
        logic [LEFT_W-1:0]  left;
        logic [RIGHT_W-1:0] right;
    } t_entry;

    typedef struct packed {
        logic               start;
        logic [X_W-1:0]     dividend;
        logic [COORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic init;
        logic div_wait;
        logic cmd_pop;
    } t_bk_status;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_DIV,
        BK_WALK,
        BK_QADDR,
        BK_QDATA,
        BK_DONE
    } t_bk_state;

endpackage

// ----- hdl/scanline_edge_table_fill_top.sv -----
// ----------------------------------------------------------------------------
// scanline_edge_table_fill_top
// per-row leftmost / rightmost column table for scanline polygon fill
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  command   | push / full        | action, x_start, y_start, x_end, y_end,
//            |                    | query_row
//  result    | empty / pop        | span_left, span_right, span_nonempty
//
//  clear sweeps every table row, one table row per cycle, before it returns a result.
//  add edge runs the bit-serial slope divider, then walks the rows the edge
//  covers; a horizontal edge skips the divider.
//  query goes through the registered table read.
//  after reset the table is swept with full held high.
//  a four-beat command queue takes beats while the back is busy or a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scanline_edge_table_fill_top_defines.svh"

module scanline_edge_table_fill_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_action,
    input  logic [9:0]                    i_x_start,
    input  logic [9:0]                    i_y_start,
    input  logic [9:0]                    i_x_end,
    input  logic [9:0]                    i_y_end,
    input  logic [9:0]                    i_query_row,
    output logic                          empty,
    input  logic                          pop,
    output logic [setf_pkg::LEFT_W-1:0]   o_span_left,
    output logic [setf_pkg::RIGHT_W-1:0]  o_span_right,
    output logic                          o_span_nonempty
);
    import setf_pkg::*;

    t_cmd         fr_cmd;
    t_cmd         q_cmd;
    logic         q_full;
    logic         q_empty;
    t_div_req     div_req;
    logic         div_done;
    logic [X_W-1:0] div_quo;
    t_bk_status   bk_st;
    logic         out_valid;

    assign full  = q_full || bk_st.init;
    assign empty = !out_valid;

    setf_front u_front (
        .i_action    (i_action),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_query_row (i_query_row),
        .o_cmd       (fr_cmd)
    );

    setf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && !full),
        .i_data  (fr_cmd),
        .i_rd    (bk_st.cmd_pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    setf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    setf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (q_cmd),
        .i_cmd_empty     (q_empty),
        .i_pop           (pop && !empty),
        .i_div_done      (div_done),
        .i_div_quotient  (div_quo),
        .o_div_req       (div_req),
        .o_status        (bk_st),
        .o_out_valid     (out_valid),
        .o_span_left     (o_span_left),
        .o_span_right    (o_span_right),
        .o_span_nonempty (o_span_nonempty)
    );

    // checks
    `SETF_ASSERT_NOW(a_no_pop_in_sweep, bk_st.init, !bk_st.cmd_pop, "command taken during sweep")
    `SETF_ASSERT_NOW(a_div_owner, div_done, bk_st.div_wait, "divider result with no edge waiting")
    `SETF_ASSERT_NEXT(a_pop_from_queue, bk_st.cmd_pop, !div_done, "divider done right after a pop")
    `SETF_ASSERT_NOW(a_span_order, !empty && o_span_nonempty,
                     o_span_left < {1'b0, o_span_right}, "nonempty span out of order")

endmodule

// ----- hdl/setf_front.sv -----
// ----------------------------------------------------------------------------
// setf_front
// classifies an incoming beat: orders edge endpoints by row, forms the
// slope operands and range-checks the query row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setf_front (
    input  logic [1:0]               i_action,
    input  logic [9:0]               i_x_start,
    input  logic [9:0]               i_y_start,
    input  logic [9:0]               i_x_end,
    input  logic [9:0]               i_y_end,
    input  logic [9:0]               i_query_row,
    output setf_pkg::t_cmd           o_cmd
);
    import setf_pkg::*;

    logic               swap;
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_y;

    always_comb begin
        swap = i_y_start > i_y_end;
        lo_x = swap ? i_x_end   : i_x_start;
        lo_y = swap ? i_y_end   : i_y_start;
        hi_x = swap ? i_x_start : i_x_end;
        hi_y = swap ? i_y_start : i_y_end;

        o_cmd.action    = t_action'(i_action);
        o_cmd.lo_x      = lo_x;
        o_cmd.lo_y      = lo_y;
        o_cmd.hi_y      = hi_y;
        o_cmd.dx_neg    = hi_x < lo_x;
        o_cmd.dx_mag    = (hi_x < lo_x) ? (lo_x - hi_x) : (hi_x - lo_x);
        o_cmd.dy        = hi_y - lo_y;
        o_cmd.flat      = (hi_y == lo_y);
        o_cmd.query_row = i_query_row;
        o_cmd.qrow_ok   = 32'(i_query_row) < 32'(ROWS);
    end

endmodule

// ----- hdl/setf_cmdq.sv -----
// ----------------------------------------------------------------------------
// setf_cmdq
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setf_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  setf_pkg::t_cmd i_data,
    input  logic           i_rd,
    output setf_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);
    import setf_pkg::*;

    t_cmd               r_slot [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_AW:0]   r_count;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = r_count == (CMDQ_AW+1)'(CMDQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/setf_div.sv -----
// ----------------------------------------------------------------------------
// setf_div
// restoring divider, one quotient bit per cycle, for the edge slope
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  setf_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [setf_pkg::X_W-1:0]      o_quotient
);
    import setf_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DIV_CW-1:0]   r_cnt;
    logic [X_W-1:0]      r_quo;
    logic [COORD_W-1:0]  r_rem;
    logic [COORD_W-1:0]  r_dvs;
    logic [COORD_W:0]    trial;
    logic                fits;

    assign trial = {r_rem, r_quo[X_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(X_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low bits are enough
            r_rem <= fits ? COORD_W'(trial - {1'b0, r_dvs}) : trial[COORD_W-1:0];
            r_quo <= {r_quo[X_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hdl/setf_back.sv -----
// ----------------------------------------------------------------------------
// setf_back
// executes commands against the row table: clearing sweep, edge walk with
// read-modify-write per row, row query, and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  setf_pkg::t_cmd                    i_cmd,
    input  logic                              i_cmd_empty,
    input  logic                              i_pop,
    input  logic                              i_div_done,
    input  logic [setf_pkg::X_W-1:0]          i_div_quotient,
    output setf_pkg::t_div_req                o_div_req,
    output setf_pkg::t_bk_status              o_status,
    output logic                              o_out_valid,
    output logic [setf_pkg::LEFT_W-1:0]       o_span_left,
    output logic [setf_pkg::RIGHT_W-1:0]      o_span_right,
    output logic                              o_span_nonempty
);
    import setf_pkg::*;

    t_bk_state            r_state;
    t_bk_state            n_state;
    logic                 cmd_pop;

    t_entry               mem [ROWS];
    t_entry               r_rd;
    logic [ROW_AW-1:0]    rd_addr;

    logic [ROW_AW-1:0]    r_clr_row;
    logic [COORD_W-1:0]   r_row;
    logic [COORD_W-1:0]   r_hi_y;
    logic [X_W-1:0]       r_x;
    logic [SLOPE_W-1:0]   r_slope;
    logic                 r_neg;
    logic [COORD_W-1:0]   r_qrow;
    logic                 r_qok;
    logic [LEFT_W-1:0]    r_pend_left;
    logic [RIGHT_W-1:0]   r_pend_right;

    logic                 r_wb_valid;
    logic [ROW_AW-1:0]    r_wb_row;
    logic [COORD_W-1:0]   r_wb_col;

    logic                 r_out_valid;
    logic [LEFT_W-1:0]    r_out_left;
    logic [RIGHT_W-1:0]   r_out_right;
    logic                 r_out_ne;

    logic                 sweeping;
    logic                 sweep_last;
    logic                 slot_free;
    logic signed [SUM_W-1:0] x_sum;
    logic [X_W-1:0]       x_next;
    logic [COORD_W-1:0]   col;
    logic [SLOPE_W-1:0]   quo_ext;
    t_entry               merged;
    t_entry               clr_entry;

    assign sweeping   = (r_state == BK_INIT) || (r_state == BK_CLEAR);
    assign sweep_last = r_clr_row == ROW_AW'(ROWS - 1);
    assign slot_free  = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        cmd_pop            = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = {i_cmd.dx_mag, FRAC_BITS'(0)};
        o_div_req.divisor  = i_cmd.dy;
        unique case (r_state)
            BK_INIT: begin
                if (sweep_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_CLEAR: begin
                if (sweep_last) begin
                    n_state = BK_DONE;
                end
            end
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    cmd_pop = 1'b1;
                    unique case (i_cmd.action)
                        ACT_CLEAR: n_state = BK_CLEAR;
                        ACT_EDGE: begin
                            if (i_cmd.flat) begin
                                n_state = BK_WALK;
                            end else begin
                                o_div_req.start = 1'b1;
                                n_state         = BK_DIV;
                            end
                        end
                        ACT_QUERY: n_state = BK_QADDR;
                        ACT_NONE:  n_state = BK_DONE;
                        default:   n_state = BK_DONE;
                    endcase
                end
            end
            BK_DIV: begin
                if (i_div_done) begin
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (r_row == r_hi_y) begin
                    n_state = BK_DONE;
                end
            end
            BK_QADDR: n_state = BK_QDATA;
            BK_QDATA: n_state = BK_DONE;
            BK_DONE: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_INIT;
        endcase
    end

    // x step with saturation to the unsigned Q10.F range
    always_comb begin
        x_sum = $signed({2'b00, r_x}) + $signed({r_slope[SLOPE_W-1], r_slope});
        if (x_sum[SUM_W-1]) begin
            x_next = '0;
        end else if (x_sum[SUM_W-2:X_W] != '0) begin
            x_next = '1;
        end else begin
            x_next = x_sum[X_W-1:0];
        end
    end

    always_comb begin
        col = r_x[X_W-1:FRAC_BITS];
        if (32'(col) > 32'(COLS - 1)) begin
            col = COORD_W'(COLS - 1);
        end
    end

    assign quo_ext = {1'b0, i_div_quotient};

    always_comb begin
        merged.left  = (LEFT_W'(r_wb_col) < r_rd.left) ? LEFT_W'(r_wb_col) : r_rd.left;
        merged.right = (r_wb_col > r_rd.right) ? r_wb_col : r_rd.right;
        clr_entry.left  = LEFT_W'(COLS);
        clr_entry.right = '0;
    end

    assign rd_addr = (r_state == BK_WALK) ? ROW_AW'(r_row) : ROW_AW'(r_qrow);

    // row table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (sweeping) begin
            mem[r_clr_row] <= clr_entry;
        end else if (r_wb_valid) begin
            mem[r_wb_row] <= merged;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row   <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (sweeping) begin
                r_clr_row <= r_clr_row + 1'b1;
            end else if (cmd_pop) begin
                r_clr_row <= '0;
            end
            r_wb_valid <= (r_state == BK_WALK) && (32'(r_row) < 32'(ROWS));
            if (r_state == BK_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_pop) begin
            r_row        <= i_cmd.lo_y;
            r_hi_y       <= i_cmd.hi_y;
            r_x          <= {i_cmd.lo_x, FRAC_BITS'(0)};
            r_slope      <= '0;
            r_neg        <= i_cmd.dx_neg;
            r_qrow       <= i_cmd.query_row;
            r_qok        <= i_cmd.qrow_ok;
            r_pend_left  <= '0;
            r_pend_right <= '0;
        end
        if (r_state == BK_DIV && i_div_done) begin
            r_slope <= r_neg ? (SLOPE_W'(0) - quo_ext) : quo_ext;
        end
        if (r_state == BK_WALK) begin
            r_row <= r_row + 1'b1;
            r_x   <= x_next;
        end
        r_wb_row <= ROW_AW'(r_row);
        r_wb_col <= col;
        if (r_state == BK_QDATA) begin
            r_pend_left  <= r_qok ? r_rd.left  : LEFT_W'(COLS);
            r_pend_right <= r_qok ? r_rd.right : '0;
        end
        if (r_state == BK_DONE && slot_free) begin
            r_out_left  <= r_pend_left;
            r_out_right <= r_pend_right;
            r_out_ne    <= r_pend_left < LEFT_W'(r_pend_right);
        end
    end

    assign o_status.init     = r_state == BK_INIT;
    assign o_status.div_wait = r_state == BK_DIV;
    assign o_status.cmd_pop  = cmd_pop;

    assign o_out_valid     = r_out_valid;
    assign o_span_left     = r_out_left;
    assign o_span_right    = r_out_right;
    assign o_span_nonempty = r_out_ne;

endmodule

// ----- tb/tb_scanline_edge_table_fill_top.sv -----
// ----------------------------------------------------------------------------
// tb_scanline_edge_table_fill_top
// self-checking bench for the scanline edge table: a queue-fed driver pushes
// clear / add-edge / query / no-op beats, a predictor keeps its own left and right
// tables, and a monitor compares every popped span with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scanline_edge_table_fill_top;

    import setf_pkg::*;

    typedef struct packed {
        t_action            act;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [COORD_W-1:0] qr;
    } t_fill_cmd;

    typedef struct packed {
        logic [LEFT_W-1:0]  left;
        logic [RIGHT_W-1:0] right;
        logic               nonempty;
    } t_span;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    logic full;
    logic empty;
    logic [LEFT_W-1:0]  o_span_left;
    logic [RIGHT_W-1:0] o_span_right;
    logic               o_span_nonempty;

    t_fill_cmd cmd_r = '0;

    t_fill_cmd pending_q[$];
    t_span     span_expect_q[$];

    // predictor tables
    logic [LEFT_W-1:0]  left_tbl  [ROWS];
    logic [RIGHT_W-1:0] right_tbl [ROWS];

    int send_idle_pct = 30;
    int recv_idle_pct = 86;
    int total_items   = 0;
    int n_counted     = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_clear       = 0;
    int n_edge        = 0;
    int n_query       = 0;
    int n_other       = 0;
    int n_filled      = 0;

    scanline_edge_table_fill_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (cmd_r.act),
        .i_x_start       (cmd_r.xs),
        .i_y_start       (cmd_r.ys),
        .i_x_end         (cmd_r.xe),
        .i_y_end         (cmd_r.ye),
        .i_query_row     (cmd_r.qr),
        .empty           (empty),
        .pop             (pop),
        .o_span_left     (o_span_left),
        .o_span_right    (o_span_right),
        .o_span_nonempty (o_span_nonempty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // span predictor
    // ------------------------------------------------------------------
    function automatic void wipe_tables();
        for (int r = 0; r < ROWS; r++) begin
            left_tbl[r]  = LEFT_W'(COLS);
            right_tbl[r] = '0;
        end
    endfunction

    function automatic void mark_column(int row, longint xf);
        int col;
        col = int'(xf >>> FRAC_BITS);
        if (col > COLS - 1) col = COLS - 1;
        if (row >= ROWS) return;
        if (col < left_tbl[row])  left_tbl[row]  = LEFT_W'(col);
        if (col > right_tbl[row]) right_tbl[row] = RIGHT_W'(col);
    endfunction

    function automatic void trace_edge(int xa, int ya, int xb, int yb);
        int     lx, ly, hx, hy, r;
        longint slope, xf, x_top;
        lx = xa; ly = ya; hx = xb; hy = yb;
        if (ya > yb) begin
            lx = xb; ly = yb; hx = xa; hy = ya;
        end
        x_top = (longint'(1) <<< X_W) - 1;
        xf = longint'(lx) <<< FRAC_BITS;
        // flat edge: only the start column lands, on its one row
        if (ly == hy) begin
            mark_column(ly, xf);
            return;
        end
        slope = (longint'(hx - lx) * (longint'(1) <<< FRAC_BITS)) / longint'(hy - ly);
        for (r = ly; r <= hy; r++) begin
            mark_column(r, xf);
            xf += slope;
            if (xf < 0) xf = 0;
            if (xf > x_top) xf = x_top;
        end
    endfunction

    function automatic void predict_span(t_fill_cmd c);
        t_span s;
        s = '0;
        case (c.act)
            ACT_CLEAR: begin
                wipe_tables();
                n_clear++;
            end
            ACT_EDGE: begin
                trace_edge(c.xs, c.ys, c.xe, c.ye);
                n_edge++;
            end
            ACT_QUERY: begin
                if (c.qr < ROWS) begin
                    s.left  = left_tbl[c.qr];
                    s.right = right_tbl[c.qr];
                end else begin
                    s.left  = LEFT_W'(COLS);
                    s.right = '0;
                end
                s.nonempty = (s.left < s.right);
                if (s.nonempty) n_filled++;
                n_query++;
            end
            default: n_other++;
        endcase
        span_expect_q.insert(span_expect_q.size(), s);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rnd_coord();
        return $urandom_range(1023, 0);
    endfunction

    function automatic void add_cmd(t_action a, int xs, int ys, int xe, int ye, int qr);
        t_fill_cmd c;
        c.act = a;
        c.xs  = COORD_W'(xs);
        c.ys  = COORD_W'(ys);
        c.xe  = COORD_W'(xe);
        c.ye  = COORD_W'(ye);
        c.qr  = COORD_W'(qr);
        pending_q.insert(pending_q.size(), c);
        if (a != ACT_NONE) n_counted++;
    endfunction

    function automatic void add_query(int row);
        add_cmd(ACT_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), row);
    endfunction

    function automatic void add_edge_cmd(int xs, int ys, int xe, int ye);
        add_cmd(ACT_EDGE, xs, ys, xe, ye, rnd_coord());
    endfunction

    // optional clear, then a closed polygon in a random box, then queries around its rows
    function automatic void add_polygon();
        int vx[5], vy[5];
        int nv, h, w, x0, y0, nq, i, j, row;
        if ($urandom_range(1, 0) == 1)
            add_cmd(ACT_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        nv = $urandom_range(5, 3);
        h  = ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(48, 1);
        w  = $urandom_range(1023, 0);
        y0 = $urandom_range(1023 - h, 0);
        x0 = $urandom_range(1023 - w, 0);
        for (i = 0; i < nv; i++) begin
            vx[i] = x0 + $urandom_range(w, 0);
            vy[i] = y0 + $urandom_range(h, 0);
            if (i > 0 && $urandom_range(5, 0) == 0) vy[i] = vy[i-1];
        end
        for (i = 0; i < nv; i++) begin
            j = (i + 1) % nv;
            if ($urandom_range(1, 0) == 1)
                add_edge_cmd(vx[i], vy[i], vx[j], vy[j]);
            else
                add_edge_cmd(vx[j], vy[j], vx[i], vy[i]);
        end
        nq = $urandom_range(6, 3);
        for (i = 0; i < nq; i++) begin
            row = y0 - 1 + $urandom_range(h + 2, 0);
            if (row < 0) row = 0;
            if (row > 1023) row = 1023;
            add_query(row);
        end
    endfunction

    function automatic void add_noise();
        t_action a;
        a = t_action'($urandom_range(3, 0));
        add_cmd(a, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        t_fill_cmd nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_span(cmd_r);
                n_accepted++;
            end
            // slot is free when nothing is held or the held beat just went
            if (!push || !full) begin
                if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    cmd_r <= nxt;
                    push  <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_span want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (span_expect_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected beat: left %0d right %0d nonempty %0d",
                                 $realtime, o_span_left, o_span_right, o_span_nonempty);
                end else begin
                    want = span_expect_q.pop_front();
                    if (o_span_left !== want.left || o_span_right !== want.right ||
                        o_span_nonempty !== want.nonempty) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, want.left, want.right, want.nonempty,
                                     o_span_left, o_span_right, o_span_nonempty);
                    end
                end
            end
            pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        wipe_tables();

        // directed: reset state, extreme edges, flat / vertical / reversed edges
        add_query(0);
        add_query(1023);
        add_edge_cmd(0, 0, 1023, 1023);
        add_edge_cmd(0, 1023, 1023, 0);
        add_query(0);
        add_query(1023);
        add_query(512);
        add_edge_cmd(5, 100, 900, 100);
        add_query(100);
        add_edge_cmd(700, 200, 700, 300);
        add_query(250);
        add_cmd(ACT_NONE, 1023, 1023, 1023, 1023, 1023);
        add_cmd(ACT_CLEAR, 1023, 1023, 1023, 1023, 1023);
        add_query(100);
        add_edge_cmd(1023, 1023, 1023, 1023);
        add_query(1023);
        add_edge_cmd(0, 10, 1023, 11);
        add_query(10);
        add_query(11);
        add_edge_cmd(1023, 5, 0, 6);
        add_query(5);
        add_query(6);
        add_edge_cmd(3, 1023, 1000, 1022);
        add_query(1022);

        n_counted = 0;
        while (n_counted < 1300) begin
            if ($urandom_range(99, 0) < 80) add_polygon();
            else add_noise();
        end
        total_items = pending_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total_items / 3) @(posedge i_clk);
        send_idle_pct <= 86;
        recv_idle_pct <= 30;
        while (n_accepted < 2 * total_items / 3) @(posedge i_clk);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;

        while (n_accepted < total_items) @(posedge i_clk);
        while (span_expect_q.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last one
        repeat (50) @(posedge i_clk);

        $display("run covered %0d clears, %0d edges, %0d queries and %0d no-op beats",
                 n_clear, n_edge, n_query, n_other);
        $display("%0d result beats checked, %0d queried spans were filled, %0d mismatches",
                 n_results, n_filled, n_errors);
        if (n_errors == 0) begin
            $display("** scanline_edge_table_fill_top: PASSED **");
        end else begin
            $display("** scanline_edge_table_fill_top: FAILED **");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #60000000;
        $display("timeout with %0d of %0d beats accepted, %0d results outstanding",
                 n_accepted, total_items, span_expect_q.size());
        $display("** scanline_edge_table_fill_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/setf_pkg.sv
hdl/setf_front.sv
hdl/setf_cmdq.sv
hdl/setf_div.sv
hdl/setf_back.sv
hdl/scanline_edge_table_fill_top.sv
tb/tb_scanline_edge_table_fill_top.sv
